### rtl/core/swa_pkg.sv
// shared types and constants of the sliding-window arq sender
package swa_pkg;

  // fixed field widths
  localparam int SEQ_W    = 10;
  localparam int PKT_W    = 11;
  localparam int LOSS_W   = 4;

  // message length clamp
  localparam int MAX_PACKETS = 1024;

  // configuration register indexes
  localparam logic [0:0] CFG_MODE  = 1'b0;
  localparam logic [0:0] CFG_TOTAL = 1'b1;

  // arq modes
  localparam logic MODE_GBN = 1'b0;
  localparam logic MODE_SR  = 1'b1;

  // result kinds
  localparam logic KIND_PKT = 1'b0;
  localparam logic KIND_SUM = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [SEQ_W-1:0]  seq;
    logic              resend;
    logic [LOSS_W-1:0] acked_mask;
    logic [PKT_W-1:0]  window_base;
    logic              done_res;
    logic              last_of_round;
  } swa_res_t;

endpackage

### rtl/core/sliding_window_arq_sender.sv
// top level of the sliding-window arq sender (go-back-n / selective repeat)
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------------
//  in_     | input     | in_valid / in_ready     | in_loss_mask
//  out_    | output    | out_valid / out_ready   | kind, seq, resend, acked_mask, window_base,
//          |           |                         | done_res, last_of_round
//  cfg_    | input     | cfg_valid / cfg_ready   | cfg_index, cfg_wdata
//
// one round goes from accept through the window walk, the slide walk and the summary:
//   n window packets walked (up to WINDOW_SLOTS), m slide steps (0..WINDOW_SLOTS),
//   one step of the shared compare/increment unit each, plus one exit compare per walk
// in_ready is high only while the sequencer is idle; one round is worked at a time
// results go through a single output register; a full register stalls the walk
// synchronous active-low reset: base 0, all slot flags clear, mode go-back-n, total 10
// cfg_ready is always high
module sliding_window_arq_sender import swa_pkg::*; #(
  parameter int WINDOW_SLOTS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  // round input
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [LOSS_W-1:0] in_loss_mask,
  // results
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_kind,
  output logic [SEQ_W-1:0]  out_seq,
  output logic              out_resend,
  output logic [LOSS_W-1:0] out_acked_mask,
  output logic [PKT_W-1:0]  out_window_base,
  output logic              out_done_res,
  output logic              out_last_of_round,
  // configuration writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [0:0]        cfg_index,
  input  logic [PKT_W-1:0]  cfg_wdata
);

  // configuration registers
  logic             mode_r, mode_nxt;
  logic [PKT_W-1:0] total_r, total_nxt;
  logic [PKT_W-1:0] eff_total;

  // output stage
  logic     out_valid_r, out_valid_nxt;
  swa_res_t out_res_r;

  logic     idle;
  logic     out_free;
  logic     push;
  swa_res_t res;

  assign cfg_ready = 1'b1;

  always_comb begin
    mode_nxt  = mode_r;
    total_nxt = total_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MODE:  mode_nxt  = cfg_wdata[0];
        CFG_TOTAL: total_nxt = cfg_wdata;
        default:   ;
      endcase
    end
  end

  // totals above the message limit act as the limit
  assign eff_total = (total_r > PKT_W'(MAX_PACKETS)) ? PKT_W'(MAX_PACKETS) : total_r;

  // a new result may load when the register is empty or being drained
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = idle;

  swa_ctrl #(.WINDOW_SLOTS(WINDOW_SLOTS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (mode_r),
    .total     (eff_total),
    .start     (in_valid),
    .loss_mask (in_loss_mask),
    .idle      (idle),
    .out_free  (out_free),
    .push      (push),
    .res       (res)
  );

  always_comb begin
    if (push) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_GBN;
      total_r     <= PKT_W'(10);
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload of the output stage, loaded on each push
  always_ff @(posedge clk) begin
    if (push) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_res_r.kind;
  assign out_seq           = out_res_r.seq;
  assign out_resend        = out_res_r.resend;
  assign out_acked_mask    = out_res_r.acked_mask;
  assign out_window_base   = out_res_r.window_base;
  assign out_done_res      = out_res_r.done_res;
  assign out_last_of_round = out_res_r.last_of_round;

endmodule

### rtl/core/swa_step_unit.sv
// shared compare and increment unit for the window and slide walks
module swa_step_unit import swa_pkg::*; #(
  parameter int WINDOW_SLOTS = 4,
  localparam int SLOT_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1
) (
  input  logic [PKT_W-1:0]  cur,
  input  logic [SLOT_W-1:0] slot,
  input  logic [PKT_W-1:0]  limit,
  output logic              lt,
  output logic [PKT_W-1:0]  cur_inc,
  output logic [SLOT_W-1:0] slot_inc
);

  assign lt      = cur < limit;
  assign cur_inc = cur + PKT_W'(1);

  // ring position wraps at the window size
  always_comb begin
    if (slot == SLOT_W'(WINDOW_SLOTS - 1)) begin
      slot_inc = '0;
    end else begin
      slot_inc = slot + SLOT_W'(1);
    end
  end

endmodule

### rtl/core/swa_ctrl.sv
// round sequencer with the per-slot sent and acknowledged flags
module swa_ctrl import swa_pkg::*; #(
  parameter int WINDOW_SLOTS = 4,
  localparam int SLOT_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              mode,
  input  logic [PKT_W-1:0]  total,
  input  logic              start,
  input  logic [LOSS_W-1:0] loss_mask,
  output logic              idle,
  input  logic              out_free,
  output logic              push,
  output swa_res_t          res
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_TX    = 2'd1;
  localparam logic [1:0] ST_SLIDE = 2'd2;
  localparam logic [1:0] ST_SUM   = 2'd3;

  logic [1:0]              state_r, state_nxt;
  logic [PKT_W-1:0]        base_r, base_nxt;
  logic [SLOT_W-1:0]       base_slot_r, base_slot_nxt;
  logic [PKT_W-1:0]        cur_r, cur_nxt;
  logic [SLOT_W-1:0]       cur_slot_r, cur_slot_nxt;
  logic [PKT_W-1:0]        end_r, end_nxt;
  logic [LOSS_W-1:0]       loss_r, loss_nxt;
  logic [LOSS_W-1:0]       kbit_r, kbit_nxt;
  logic [LOSS_W-1:0]       newly_r, newly_nxt;
  logic [WINDOW_SLOTS-1:0] acked_r, acked_nxt;
  logic [WINDOW_SLOTS-1:0] sent_r, sent_nxt;

  logic [PKT_W-1:0]  u_cur, u_limit, u_cur_inc;
  logic [SLOT_W-1:0] u_slot, u_slot_inc;
  logic              u_lt;
  logic [PKT_W:0]    win_end;
  logic              emit;

  swa_step_unit #(.WINDOW_SLOTS(WINDOW_SLOTS)) u_step (
    .cur      (u_cur),
    .slot     (u_slot),
    .limit    (u_limit),
    .lt       (u_lt),
    .cur_inc  (u_cur_inc),
    .slot_inc (u_slot_inc)
  );

  assign idle    = (state_r == ST_IDLE);
  assign win_end = {1'b0, base_r} + (PKT_W+1)'(WINDOW_SLOTS);

  always_comb begin
    if (state_r == ST_TX) begin
      u_cur   = cur_r;
      u_slot  = cur_slot_r;
      u_limit = end_r;
    end else begin
      u_cur   = base_r;
      u_slot  = base_slot_r;
      u_limit = total;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    base_nxt      = base_r;
    base_slot_nxt = base_slot_r;
    cur_nxt       = cur_r;
    cur_slot_nxt  = cur_slot_r;
    end_nxt       = end_r;
    loss_nxt      = loss_r;
    kbit_nxt      = kbit_r;
    newly_nxt     = newly_r;
    acked_nxt     = acked_r;
    sent_nxt      = sent_r;
    push          = 1'b0;
    res           = '0;
    emit          = (mode == MODE_GBN) || !sent_r[cur_slot_r] || !acked_r[cur_slot_r];
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          loss_nxt     = loss_mask;
          kbit_nxt     = LOSS_W'(1);
          newly_nxt    = '0;
          cur_nxt      = base_r;
          cur_slot_nxt = base_slot_r;
          end_nxt      = (win_end > {1'b0, total}) ? total : win_end[PKT_W-1:0];
          state_nxt    = ST_TX;
        end
      end
      ST_TX: begin
        if (!u_lt) begin
          state_nxt = ST_SLIDE;
        end else if (!emit || out_free) begin
          if (emit) begin
            push                 = 1'b1;
            res.kind             = KIND_PKT;
            res.seq              = cur_r[SEQ_W-1:0];
            res.resend           = sent_r[cur_slot_r];
            res.window_base      = base_r;
            sent_nxt[cur_slot_r] = 1'b1;
          end
          // acknowledgement of this slot, loss bits only cover the first slots
          if (!acked_r[cur_slot_r] && !loss_r[0]) begin
            acked_nxt[cur_slot_r] = 1'b1;
            newly_nxt             = newly_r | kbit_r;
          end
          loss_nxt     = loss_r >> 1;
          kbit_nxt     = kbit_r << 1;
          cur_nxt      = u_cur_inc;
          cur_slot_nxt = u_slot_inc;
        end
      end
      ST_SLIDE: begin
        if (u_lt && acked_r[base_slot_r]) begin
          acked_nxt[base_slot_r] = 1'b0;
          sent_nxt[base_slot_r]  = 1'b0;
          base_nxt               = u_cur_inc;
          base_slot_nxt          = u_slot_inc;
        end else begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        if (out_free) begin
          push              = 1'b1;
          res.kind          = KIND_SUM;
          res.acked_mask    = newly_r;
          res.window_base   = base_r;
          res.done_res      = !u_lt;
          res.last_of_round = 1'b1;
          state_nxt         = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      base_r      <= '0;
      base_slot_r <= '0;
      acked_r     <= '0;
      sent_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      base_slot_r <= base_slot_nxt;
      acked_r     <= acked_nxt;
      sent_r      <= sent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    cur_slot_r <= cur_slot_nxt;
    end_r      <= end_nxt;
    loss_r     <= loss_nxt;
    kbit_r     <= kbit_nxt;
    newly_r    <= newly_nxt;
  end

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> out_free)
    else $error("result pushed into a full output stage");

  a_summary_ends_round: assert property (@(posedge clk) disable iff (!rst_n)
    (push && res.last_of_round) |=> (state_r == ST_IDLE))
    else $error("round did not end after its summary");

  a_base_moves_in_slide: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(base_r)) |-> $past(state_r == ST_SLIDE))
    else $error("window base moved outside the slide walk");

  a_no_push_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !push)
    else $error("result pushed while idle");

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench of the sliding-window arq sender, driven round by round
module testbench;
  import swa_pkg::*;

  // dut ports, every input known from time zero
  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [LOSS_W-1:0] in_loss_mask = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_kind;
  logic [SEQ_W-1:0]  out_seq;
  logic              out_resend;
  logic [LOSS_W-1:0] out_acked_mask;
  logic [PKT_W-1:0]  out_window_base;
  logic              out_done_res;
  logic              out_last_of_round;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [0:0]        cfg_index = CFG_MODE;
  logic [PKT_W-1:0]  cfg_wdata = '0;

  // predictor copy of the sender: configuration plus window state
  logic              arq_mode = MODE_GBN;
  logic [PKT_W-1:0]  total_cfg = PKT_W'(10);
  int unsigned       win_base = 0;
  int unsigned       high_seq = 0;
  logic [3:0]        acked_slots = '0;
  logic [3:0]        sent_slots = '0;

  // results still owed by the dut, oldest first
  swa_res_t          owed_results[$];

  int unsigned       rounds_sent = 0;
  int unsigned       results_checked = 0;
  int unsigned       fail_count = 0;

  // idle percentages, switched by the round count
  int unsigned       send_idle_pct = 33;
  int unsigned       recv_idle_pct = 70;

  sliding_window_arq_sender dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_loss_mask      (in_loss_mask),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_seq           (out_seq),
    .out_resend        (out_resend),
    .out_acked_mask    (out_acked_mask),
    .out_window_base   (out_window_base),
    .out_done_res      (out_done_res),
    .out_last_of_round (out_last_of_round),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // receiver side: random back-pressure on the result channel
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // work out one round: transmissions, then acks, then the slide and the summary
  function automatic void predict_round(input logic [3:0] loss);
    int unsigned eff_total;
    int unsigned win_end;
    int unsigned slot;
    logic [3:0]  newly;
    swa_res_t    r;
    eff_total = (total_cfg > MAX_PACKETS) ? MAX_PACKETS : total_cfg;
    win_end = win_base + 4;
    if (win_end > eff_total) win_end = eff_total;
    newly = '0;

    // go-back-n sends the whole window, selective repeat skips acked packets
    for (int unsigned s = win_base; s < win_end; s++) begin
      slot = s % 4;
      if (arq_mode == MODE_GBN || !sent_slots[slot] || !acked_slots[slot]) begin
        r = '0;
        r.kind = KIND_PKT;
        r.seq = SEQ_W'(s);
        r.resend = sent_slots[slot];
        r.window_base = PKT_W'(win_base);
        owed_results.push_back(r);
        sent_slots[slot] = 1'b1;
      end
    end
    if (win_end > high_seq) high_seq = win_end;

    // acks land for every unacked window packet whose loss bit is clear
    for (int unsigned s = win_base; s < win_end; s++) begin
      slot = s % 4;
      if (!acked_slots[slot] && !loss[s - win_base]) begin
        acked_slots[slot] = 1'b1;
        newly[s - win_base] = 1'b1;
      end
    end

    // slide past every acked packet at the base, freeing its slot
    while (win_base < eff_total && acked_slots[win_base % 4]) begin
      acked_slots[win_base % 4] = 1'b0;
      sent_slots[win_base % 4] = 1'b0;
      win_base++;
    end

    r = '0;
    r.kind = KIND_SUM;
    r.acked_mask = newly;
    r.window_base = PKT_W'(win_base);
    r.done_res = (win_base >= eff_total);
    r.last_of_round = 1'b1;
    owed_results.push_back(r);
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // result checker: every accepted transaction against the oldest owed result
  always @(posedge clk) begin : result_check
    swa_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (owed_results.size() == 0) begin
        $error("result with no expectation waiting: kind %0d seq %0d", out_kind, out_seq);
        fail_count++;
      end else begin
        want = owed_results.pop_front();
        results_checked++;
        check_field("kind", want.kind, out_kind);
        check_field("seq", want.seq, out_seq);
        check_field("resend", want.resend, out_resend);
        check_field("acked_mask", want.acked_mask, out_acked_mask);
        check_field("window_base", want.window_base, out_window_base);
        check_field("done_res", want.done_res, out_done_res);
        check_field("last_of_round", want.last_of_round, out_last_of_round);
      end
    end
  end

  // one round transaction; valid is left high so a following round can go back to back
  task automatic send_round(input logic [3:0] loss);
    int unsigned gap;
    gap = 0;
    // idle regimes: sender light / receiver heavy, then swapped, then none
    if (rounds_sent < 77) begin
      send_idle_pct = 33;
      recv_idle_pct = 70;
    end else if (rounds_sent < 154) begin
      send_idle_pct = 70;
      recv_idle_pct = 33;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_loss_mask <= loss;
    do @(posedge clk); while (!in_ready);
    predict_round(loss);
    rounds_sent++;
  endtask

  // drop valid and hold off until every owed result is out and the sequencer is idle
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (owed_results.size() != 0 || !in_ready);
  endtask

  // write both registers, mode first; valid stays high across the pair
  task automatic set_config(input logic m, input int unsigned total);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_MODE;
    cfg_wdata <= PKT_W'(m);
    do @(posedge clk); while (!cfg_ready);
    arq_mode = m;
    cfg_index <= CFG_TOTAL;
    cfg_wdata <= PKT_W'(total);
    do @(posedge clk); while (!cfg_ready);
    total_cfg = PKT_W'(total);
    cfg_valid <= 1'b0;
  endtask

  // reset values: go-back-n, ten packets; all lost, all acked, partial losses
  task automatic test_reset_config();
    logic [3:0] masks [4] = '{4'hF, 4'h0, 4'h5, 4'h8};
    foreach (masks[i]) send_round(masks[i]);
    wait_idle();
  endtask

  // go-back-n to the end of the short message, plus one round after it is done
  task automatic test_go_back_n();
    logic [3:0] masks [3] = '{4'h2, 4'h0, 4'h0};
    foreach (masks[i]) send_round(masks[i]);
    wait_idle();
  endtask

  // selective repeat over nine packets with scattered losses, finished at the end
  task automatic test_selective_repeat();
    logic [3:0] masks [7] = '{4'hF, 4'h6, 4'h9, 4'h0, 4'h0, 4'h0, 4'h0};
    set_config(MODE_SR, win_base + 9);
    foreach (masks[i]) send_round(masks[i]);
    wait_idle();
  endtask

  // empty message, total below base, oversize total, total cut to the base mid-message
  task automatic test_total_edges();
    set_config(MODE_SR, 0);
    send_round(4'h3);
    wait_idle();
    set_config(MODE_GBN, 1);
    send_round(4'h0);
    wait_idle();
    set_config(MODE_GBN, 2047);
    send_round(4'hC);
    send_round(4'h3);
    wait_idle();
    // acked packets ahead of the base stay flagged after the cut
    set_config(MODE_SR, win_base);
    send_round(4'h0);
    wait_idle();
  endtask

  // phases of random rounds; each phase picks a mode and a total, often mid-message
  task automatic test_random_phases(input int unsigned n_rounds);
    int unsigned stop;
    int unsigned total;
    int unsigned pick;
    int unsigned phase_len;
    logic        m;
    logic [3:0]  loss;
    stop = rounds_sent + n_rounds;
    while (rounds_sent < stop) begin
      m = $urandom_range(0, 1) ? MODE_SR : MODE_GBN;
      pick = $urandom_range(0, 9);
      if (pick == 0) total = 0;
      else if (pick == 1) total = $urandom_range(0, win_base);
      else if (pick == 2) total = $urandom_range(MAX_PACKETS + 1, 2047);
      else total = win_base + $urandom_range(1, 24);
      set_config(m, total);
      phase_len = $urandom_range(1, 12);
      repeat (phase_len) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) loss = 4'h0;
        else if (pick < 8) loss = 4'($urandom_range(0, 15));
        else if (pick == 8) loss = 4'(1 << $urandom_range(0, 3));
        else loss = 4'hF;
        send_round(loss);
      end
      // sender holds off here until the dut has emptied out
      wait_idle();
    end
  endtask

  // oversize total acts as the packet limit: a long run with occasional losses
  task automatic test_clamp_drain(input int unsigned n_rounds);
    set_config($urandom_range(0, 1) ? MODE_SR : MODE_GBN, 2047);
    repeat (n_rounds) begin
      send_round(($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : 4'h0);
    end
    wait_idle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_config();
    test_go_back_n();
    test_selective_repeat();
    test_total_edges();
    test_random_phases(170);
    test_clamp_drain(36);
    repeat (20) @(posedge clk);
    $display("rounds sent %0d, results checked %0d, highest sequence end %0d",
             rounds_sent, results_checked, high_seq);
    $display("both arq modes, totals from empty to oversize, base driven to %0d", win_base);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog far beyond the slowest legal run
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
